// ===== src/checked_int64_alu_unit_defines.svh =====
// Assertion macros for the checked 64-bit ALU.
`ifndef CHECKED_INT64_ALU_UNIT_DEFINES_SVH
`define CHECKED_INT64_ALU_UNIT_DEFINES_SVH
// Property a implies property b on the next clock edge.
`define CIA_ASSERT_NEXT(label, a, b) \
   label: assert property (@(posedge clock) disable iff (reset) (a) |=> (b)) \
      else $error("assertion failed");
// Property a implies property b on the same clock edge.
`define CIA_ASSERT_NOW(label, a, b) \
   label: assert property (@(posedge clock) disable iff (reset) (a) |-> (b)) \
      else $error("assertion failed");
`endif

// ===== src/cia_pkg.sv =====
// Shared types and constants for the checked 64-bit ALU.
`timescale 1ns / 1ps
package cia_pkg;
   localparam logic [3:0] FUNC_ADD = 4'd0;
   localparam logic [3:0] FUNC_SUB = 4'd1;
   localparam logic [3:0] FUNC_MUL = 4'd2;
   localparam logic [3:0] FUNC_DIV = 4'd3;
   localparam logic [3:0] FUNC_REM = 4'd4;
   localparam logic [3:0] FUNC_AND = 4'd5;
   localparam logic [3:0] FUNC_OR  = 4'd6;
   localparam logic [3:0] FUNC_SHL = 4'd7;
   localparam logic [3:0] FUNC_SHR = 4'd8;
   localparam logic [3:0] FUNC_POW = 4'd9;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_OVERFLOW = 3'd1;
   localparam logic [2:0] ST_DIVZERO  = 3'd2;
   localparam logic [2:0] ST_BADSHIFT = 3'd3;
   localparam logic [2:0] ST_BADEXP   = 3'd4;
   localparam logic [2:0] ST_BIGBASE  = 3'd5;

   localparam logic [63:0] MAX_SHIFT = 64'd62;
   localparam logic [63:0] MAX_EXP   = 64'd63;
   localparam logic [63:0] MAX_BASE  = 64'd65535;

   // Datapath operation classes chosen by the controller.
   localparam logic [1:0] OP_SINGLE = 2'd0;
   localparam logic [1:0] OP_DIV    = 2'd1;
   localparam logic [1:0] OP_MUL    = 2'd2;
   localparam logic [1:0] OP_POW    = 2'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       load;     // capture operands and set up the unit
      logic       step;     // run one iteration of the active unit
      logic       finish;   // form the result value and status
      logic [1:0] op_class;
   } cia_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic       early;    // operation needs no iterations
      logic       last;     // current iteration is the final one
   } cia_stat_type;
endpackage

// ===== src/cia_ctrl.sv =====
// Controller state machine for the checked 64-bit ALU.
`timescale 1ns / 1ps
module cia_ctrl
   import cia_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [3:0]   req_func,
   input  cia_stat_type stat,
   output cia_cmd_type  cmd,
   output logic         busy,
   output logic         rsp_valid
);
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_RUN  = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   logic [1:0] state_ff, state_in;
   logic [1:0] class_ff, class_in;
   logic       valid_ff, valid_in;
   logic [1:0] req_class;

   // Map the opcode to a datapath class.
   always_comb begin
      unique case (req_func)
         FUNC_MUL:           req_class = OP_MUL;
         FUNC_DIV, FUNC_REM: req_class = OP_DIV;
         FUNC_POW:           req_class = OP_POW;
         default:            req_class = OP_SINGLE;
      endcase
   end

   // Next state and command decode.
   always_comb begin
      state_in = state_ff;
      class_in = class_ff;
      valid_in = 1'b0;
      cmd      = '0;
      cmd.op_class = class_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load     = 1'b1;
               cmd.op_class = req_class;
               class_in     = req_class;
               state_in     = S_RUN;
            end
         end
         S_RUN: begin
            if (stat.early) begin
               state_in = S_DONE;
            end else begin
               cmd.step = 1'b1;
               if (stat.last) state_in = S_DONE;
            end
         end
         S_DONE: begin
            cmd.finish = 1'b1;
            valid_in   = 1'b1;
            state_in   = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         class_ff <= OP_SINGLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         class_ff <= class_in;
         valid_ff <= valid_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = valid_ff;
endmodule

// ===== src/cia_datapath.sv =====
// Datapath of the checked 64-bit ALU: operand registers, divider and multiplier.
`timescale 1ns / 1ps
module cia_datapath
   import cia_pkg::*;
(
   input  logic         clock,
   input  cia_cmd_type  cmd,
   input  logic [3:0]   req_func,
   input  logic [63:0]  req_lhs,
   input  logic [63:0]  req_rhs,
   output cia_stat_type stat,
   output logic [63:0]  rsp_value,
   output logic [2:0]   rsp_status
);
   // Phases of one square-and-multiply round on the 32-bit multiplier.
   localparam logic [2:0] PH_ACC_LL = 3'd0;
   localparam logic [2:0] PH_ACC_LH = 3'd1;
   localparam logic [2:0] PH_ACC_HL = 3'd2;
   localparam logic [2:0] PH_SQ_LL  = 3'd3;
   localparam logic [2:0] PH_SQ_LH  = 3'd4;
   localparam logic [2:0] PH_SQ_HL  = 3'd5;

   logic [3:0]  func_ff;
   logic [63:0] a_ff, b_ff;
   logic [63:0] acc_ff, acc_in;     // quotient / product / power accumulator
   logic [63:0] rem_ff, rem_in;     // partial remainder / power base
   logic [63:0] mcand_ff, mcand_in; // divisor magnitude / multiplicand shifter
   logic [63:0] mplier_ff, mplier_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic [2:0]  ph_ff, ph_in;
   logic [63:0] part_ff, part_in;
   logic [63:0] val_ff, val_in;
   logic [2:0]  st_ff, st_in;

   logic [63:0] mag_a, mag_b;
   logic [64:0] trial;
   logic [63:0] shifted_rem;
   logic [63:0] sum, diff;
   logic [31:0] mul_x, mul_y;
   logic [63:0] mul_p;
   logic [63:0] part_sum;

   assign mag_a = req_lhs[63] ? (64'd0 - req_lhs) : req_lhs;
   assign mag_b = req_rhs[63] ? (64'd0 - req_rhs) : req_rhs;

   // One restoring-division step: shift in the next dividend bit, try subtract.
   assign shifted_rem = {rem_ff[62:0], acc_ff[63]};
   assign trial = {rem_ff, acc_ff[63]} - {1'b0, mcand_ff};

   // Operand select for the 32-bit multiplier; each 64-bit product takes the
   // low-by-low, low-by-high and high-by-low partial products in turn.
   always_comb begin
      case (ph_ff)
         PH_ACC_LL: begin
            mul_x = acc_ff[31:0];
            mul_y = rem_ff[31:0];
         end
         PH_ACC_LH: begin
            mul_x = acc_ff[31:0];
            mul_y = rem_ff[63:32];
         end
         PH_ACC_HL: begin
            mul_x = acc_ff[63:32];
            mul_y = rem_ff[31:0];
         end
         PH_SQ_LL: begin
            mul_x = rem_ff[31:0];
            mul_y = rem_ff[31:0];
         end
         PH_SQ_LH: begin
            mul_x = rem_ff[31:0];
            mul_y = rem_ff[63:32];
         end
         default: begin
            mul_x = rem_ff[63:32];
            mul_y = rem_ff[31:0];
         end
      endcase
   end

   assign mul_p    = {32'd0, mul_x} * {32'd0, mul_y};
   assign part_sum = part_ff + {mul_p[31:0], 32'd0};

   assign stat.early = (cmd.op_class == OP_SINGLE)
                       || (cmd.op_class == OP_DIV && b_ff == 64'd0)
                       || (cmd.op_class == OP_POW && st_ff != ST_OK);
   assign stat.last  = (cmd.op_class == OP_POW) ? (cnt_ff == 7'd5 && ph_ff == PH_SQ_HL)
                                                : (cnt_ff == 7'd63);

   // Iteration control for divide, shift-add multiply and square-and-multiply.
   always_comb begin
      acc_in    = acc_ff;
      rem_in    = rem_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      cnt_in    = cnt_ff;
      ph_in     = ph_ff;
      part_in   = part_ff;
      if (cmd.load) begin
         cnt_in = 7'd0;
         ph_in  = PH_ACC_LL;
         unique case (cmd.op_class)
            OP_DIV: begin
               acc_in   = mag_a;
               rem_in   = 64'd0;
               mcand_in = mag_b;
            end
            OP_MUL: begin
               acc_in    = 64'd0;
               mcand_in  = req_lhs;
               mplier_in = req_rhs;
            end
            OP_POW: begin
               acc_in    = 64'd1;
               rem_in    = req_lhs;
               mplier_in = req_rhs;
            end
            default: ;
         endcase
      end else if (cmd.step) begin
         unique case (cmd.op_class)
            OP_DIV: begin
               cnt_in = cnt_ff + 7'd1;
               if (!trial[64]) begin
                  rem_in = trial[63:0];
                  acc_in = {acc_ff[62:0], 1'b1};
               end else begin
                  rem_in = shifted_rem;
                  acc_in = {acc_ff[62:0], 1'b0};
               end
            end
            OP_MUL: begin
               cnt_in = cnt_ff + 7'd1;
               if (mplier_ff[0]) acc_in = acc_ff + mcand_ff;
               mcand_in  = {mcand_ff[62:0], 1'b0};
               mplier_in = {1'b0, mplier_ff[63:1]};
            end
            OP_POW: begin
               // Multiply the accumulator by the base when the exponent bit is set, then square the base.
               ph_in = ph_ff + 3'd1;
               case (ph_ff)
                  PH_ACC_LL, PH_SQ_LL: part_in = mul_p;
                  PH_ACC_LH, PH_SQ_LH: part_in = part_sum;
                  PH_ACC_HL: begin
                     if (mplier_ff[0]) acc_in = part_sum;
                  end
                  default: begin
                     rem_in    = part_sum;
                     mplier_in = {1'b0, mplier_ff[63:1]};
                     cnt_in    = cnt_ff + 7'd1;
                     ph_in     = PH_ACC_LL;
                  end
               endcase
            end
            default: ;
         endcase
      end
   end

   assign sum  = a_ff + b_ff;
   assign diff = a_ff - b_ff;

   // Result formation; pow range checks are settled at load.
   always_comb begin
      val_in = val_ff;
      st_in  = st_ff;
      if (cmd.load) begin
         st_in = ST_OK;
         if (req_func == FUNC_POW) begin
            if (req_rhs > MAX_EXP)                         st_in = ST_BADEXP;
            else if (!req_lhs[63] && req_lhs > MAX_BASE)   st_in = ST_BIGBASE;
         end
      end else if (cmd.finish) begin
         st_in  = ST_OK;
         val_in = 64'd0;
         case (func_ff)
            FUNC_ADD: begin
               val_in = sum;
               if ((a_ff[63] ~^ b_ff[63]) && (sum[63] != a_ff[63])) st_in = ST_OVERFLOW;
            end
            FUNC_MUL: val_in = acc_ff;
            FUNC_DIV: begin
               if (b_ff == 64'd0) st_in = ST_DIVZERO;
               else val_in = (a_ff[63] ^ b_ff[63]) ? (64'd0 - acc_ff) : acc_ff;
            end
            FUNC_REM: begin
               if (b_ff == 64'd0) st_in = ST_DIVZERO;
               else val_in = a_ff[63] ? (64'd0 - rem_ff) : rem_ff;
            end
            FUNC_AND: val_in = a_ff & b_ff;
            FUNC_OR:  val_in = a_ff | b_ff;
            FUNC_SHL: begin
               if (b_ff > MAX_SHIFT) st_in = ST_BADSHIFT;
               else val_in = a_ff << b_ff[5:0];
            end
            FUNC_SHR: begin
               if (b_ff > MAX_SHIFT) st_in = ST_BADSHIFT;
               else val_in = $signed(a_ff) >>> b_ff[5:0];
            end
            FUNC_POW: begin
               st_in = st_ff;
               if (st_ff == ST_OK) val_in = acc_ff;
            end
            default: begin
               val_in = diff;
               if ((a_ff[63] != b_ff[63]) && (diff[63] != a_ff[63])) st_in = ST_OVERFLOW;
            end
         endcase
         if (st_in != ST_OK) val_in = 64'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= req_func;
         a_ff    <= req_lhs;
         b_ff    <= req_rhs;
      end
      acc_ff    <= acc_in;
      rem_ff    <= rem_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      cnt_ff    <= cnt_in;
      ph_ff     <= ph_in;
      part_ff   <= part_in;
      val_ff    <= val_in;
      st_ff     <= st_in;
   end

   assign rsp_value  = val_ff;
   assign rsp_status = st_ff;
endmodule

// ===== src/checked_int64_alu_unit.sv =====
// Top level of the checked signed 64-bit ALU.
//
// Usage: drive req_func, req_lhs and req_rhs and raise start while busy is
// low; that edge accepts the transaction. Busy stays high until the result
// is presented. The result appears on rsp_value and rsp_status for exactly
// one cycle, marked by rsp_valid; the receiver cannot stall it.
// Work from the accepting edge to the result strobe:
//   add, sub, and, or, shifts and unknown opcodes: no iterations;
//   div, rem and mul: 64 iterations of a one-bit divider or
//   shift-add multiplier, or none for a zero divisor;
//   pow: six square-and-multiply rounds of six phases each on a
//   32-bit multiplier, or none on a range error.
// Busy is low during the strobe cycle, so a new transaction can be taken at
// the edge that ends it; while a transaction is in progress, no new one is
// accepted.
// Synchronous reset returns the controller to idle and drops rsp_valid.
`timescale 1ns / 1ps
`include "checked_int64_alu_unit_defines.svh"
module checked_int64_alu_unit
   import cia_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [3:0]  req_func,
   input  logic [63:0] req_lhs,
   input  logic [63:0] req_rhs,
   output logic        rsp_valid,
   output logic [63:0] rsp_value,
   output logic [2:0]  rsp_status
);
   cia_cmd_type  cmd;
   cia_stat_type stat;

   cia_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .req_func(req_func),
      .stat(stat), .cmd(cmd), .busy(busy), .rsp_valid(rsp_valid)
   );

   cia_datapath u_dp (
      .clock(clock), .cmd(cmd), .req_func(req_func), .req_lhs(req_lhs),
      .req_rhs(req_rhs), .stat(stat), .rsp_value(rsp_value),
      .rsp_status(rsp_status)
   );

   // A result strobe lasts one cycle.
   `CIA_ASSERT_NEXT(a_strobe_single, rsp_valid, !rsp_valid)
   // Any error status carries a zero value.
   `CIA_ASSERT_NOW(a_err_zero, rsp_valid && rsp_status != ST_OK, rsp_value == 64'd0)
   // An accepted transaction makes the block busy.
   `CIA_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
endmodule
